// File: rtl/pvk_pkg.sv
// ----------------------------------------------------------------------------
// pvk_pkg
// Types, constants and helpers shared by the position/velocity tracker.
// ----------------------------------------------------------------------------
package pvk_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int WIDE_W = 2 * WORD_W + 2;
    localparam int MUL_A_W = WORD_W + 1;
    localparam int MUL_P_W = MUL_A_W + WORD_W;
    localparam int DIV_N_W = WORD_W + 1 + FRAC_W;
    localparam int DIV_D_W = WORD_W + 1;
    localparam int GAIN_W = FRAC_W + 1;
    localparam int CNT_W = 6;
    localparam int AXES = 3;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_N_W - 1);
    localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_PREDICT = 2'd1,
        REQ_UPDATE  = 2'd2,
        REQ_PROJECT = 2'd3
    } t_req_type;

    localparam logic [1:0] CFG_Q  = 2'd0;
    localparam logic [1:0] CFG_R  = 2'd1;
    localparam logic [1:0] CFG_DT = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] in_x;
        logic signed [WORD_W-1:0] in_y;
        logic signed [WORD_W-1:0] in_z;
        logic signed [WORD_W-1:0] in_vx;
        logic signed [WORD_W-1:0] in_vy;
        logic signed [WORD_W-1:0] in_vz;
        logic [WORD_W-1:0]        horizon;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] est_x;
        logic signed [WORD_W-1:0] est_y;
        logic signed [WORD_W-1:0] est_z;
        logic signed [WORD_W-1:0] est_vx;
        logic signed [WORD_W-1:0] est_vy;
        logic signed [WORD_W-1:0] est_vz;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADV_MUL,
        ST_ADV_DONE,
        ST_GAIN_DIV,
        ST_GAIN_DONE,
        ST_CORR_MUL,
        ST_CORR_DONE,
        ST_VAR_MUL,
        ST_VAR_DONE,
        ST_VEL_DIV,
        ST_VEL_DONE,
        ST_NEXT,
        ST_OUT
    } t_state;

    // clamp a wide signed value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_s(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            sat_s = hi[WORD_W-1:0];
        end else if (v < lo) begin
            sat_s = lo[WORD_W-1:0];
        end else begin
            sat_s = v[WORD_W-1:0];
        end
    endfunction

endpackage

// File: rtl/pvk_req_if.sv
// ----------------------------------------------------------------------------
// pvk_req_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface pvk_req_if;
    logic          valid;
    logic          ready;
    pvk_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pvk_res_if.sv
// ----------------------------------------------------------------------------
// pvk_res_if
// Result channel: valid/ready handshake with one estimate item.
// ----------------------------------------------------------------------------
interface pvk_res_if;
    logic          valid;
    logic          ready;
    pvk_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/position_velocity_kalman_tracker_core.sv
// ----------------------------------------------------------------------------
// position_velocity_kalman_tracker_core
// Three-axis scalar Kalman tracker in Q16.16 with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One request is taken at a time and the three axes are worked in turn through
// a shared shift-add multiplier and a shared restoring divider, one bit per
// cycle. An update takes two divisions and two multiplications per axis. An
// update whose gain denominator is zero skips its arithmetic for that axis. The
// result sits in an output register, so the next request is taken while the
// previous result waits for its transfer.
module position_velocity_kalman_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    pvk_req_if.sink     i_req,
    pvk_res_if.source   o_res
);

    localparam int W  = pvk_pkg::WORD_W;
    localparam int F  = pvk_pkg::FRAC_W;
    localparam int WW = pvk_pkg::WIDE_W;
    localparam int AW = pvk_pkg::MUL_A_W;
    localparam int PW = pvk_pkg::MUL_P_W;
    localparam int NW = pvk_pkg::DIV_N_W;
    localparam int DW = pvk_pkg::DIV_D_W;
    localparam int GW = pvk_pkg::GAIN_W;

    // configuration registers
    logic [W-1:0] r_q, r_r, r_dt;

    // filter state per axis
    logic signed [W-1:0] r_pos [pvk_pkg::AXES];
    logic signed [W-1:0] r_vel [pvk_pkg::AXES];
    logic [W-1:0]        r_var [pvk_pkg::AXES];
    logic signed [W-1:0] r_res [pvk_pkg::AXES];

    // sequencer
    pvk_pkg::t_state r_state, n_state;
    pvk_pkg::t_req   r_req;
    logic [1:0]      r_axis;
    logic [pvk_pkg::CNT_W-1:0] r_cnt;

    // serial multiplier: product register shares its low half with the multiplier
    logic [AW-1:0] r_mul_a;
    logic [PW-1:0] r_mul_p;
    logic          r_neg;

    // serial divider
    logic [DW-1:0] r_div_rem;
    logic [NW-1:0] r_div_q;
    logic [DW-1:0] r_div_d;

    logic [GW-1:0]       r_gain;
    logic signed [W:0]   r_delta;

    // output register
    logic          r_out_valid;
    pvk_pkg::t_res r_out;

    // control decoded from the state
    logic w_in_ready;
    logic w_out_load;
    logic w_mul_step;
    logic w_div_step;

    // ------------------------------------------------------------------------
    // per-axis operand selection
    logic signed [W-1:0] w_pin, w_vin, w_pos, w_vel;
    logic [W-1:0]        w_var;
    always_comb begin
        w_pos = r_pos[r_axis];
        w_vel = r_vel[r_axis];
        w_var = r_var[r_axis];
        unique case (r_axis)
            2'd0: begin
                w_pin = r_req.in_x;
                w_vin = r_req.in_vx;
            end
            2'd1: begin
                w_pin = r_req.in_y;
                w_vin = r_req.in_vy;
            end
            default: begin
                w_pin = r_req.in_z;
                w_vin = r_req.in_vz;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // one multiplier bit: add the multiplicand into the top half, shift right
    logic [AW:0]   w_mul_sum;
    logic [PW-1:0] w_mul_next;
    always_comb begin
        w_mul_sum  = {1'b0, r_mul_p[PW-1:W]} + (r_mul_p[0] ? {1'b0, r_mul_a} : '0);
        w_mul_next = {w_mul_sum, r_mul_p[W-1:1]};
    end

    // signed product rounded toward minus infinity
    logic signed [WW-1:0] w_prod;
    logic signed [WW-1:0] w_prod_fl;
    logic signed [WW-1:0] w_pos_sum;
    always_comb begin
        w_prod    = $signed({1'b0, r_mul_p});
        if (r_neg) begin
            w_prod = -w_prod;
        end
        w_prod_fl = w_prod >>> F;
        w_pos_sum = WW'(w_pos) + w_prod_fl;
    end

    // one divider bit: restoring step
    logic [DW:0]   w_rem_sh;
    logic [DW:0]   w_rem_sub;
    logic          w_ge;
    always_comb begin
        w_rem_sh  = {r_div_rem, r_div_q[NW-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_div_d};
        w_ge      = (w_rem_sh >= {1'b0, r_div_d});
    end

    // update operands
    logic [DW-1:0]        w_s;
    logic signed [W:0]    w_diff;
    logic [W:0]           w_diff_mag;
    logic [W:0]           w_delta_mag;
    logic [W-1:0]         w_vel_mag;
    logic [GW-1:0]        w_gain;
    logic signed [W-1:0]  w_nx;
    logic signed [WW-1:0] w_vel_q;
    logic [PW-F-1:0]      w_var_sh;
    logic [W-1:0]         w_var_new;
    always_comb begin
        w_s         = {1'b0, w_var} + {1'b0, r_r};
        w_diff      = $signed({w_pin[W-1], w_pin}) - $signed({w_pos[W-1], w_pos});
        w_diff_mag  = w_diff[W] ? (W+1)'(-w_diff) : w_diff;
        w_delta_mag = r_delta[W] ? (W+1)'(-r_delta) : r_delta;
        w_vel_mag   = w_vel[W-1] ? W'(-w_vel) : w_vel;
        w_gain      = (r_div_q > NW'(pvk_pkg::ONE_Q)) ? pvk_pkg::ONE_Q : r_div_q[GW-1:0];
        w_nx        = pvk_pkg::sat_s(w_pos_sum);
        w_vel_q     = WW'($signed({1'b0, r_div_q}));
        if (r_neg) begin
            w_vel_q = -w_vel_q;
        end
        w_var_sh    = r_mul_p[PW-1:F];
        w_var_new   = (w_var_sh > (PW-F)'({W{1'b1}})) ? {W{1'b1}} : w_var_sh[W-1:0];
    end

    // ------------------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pvk_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = pvk_pkg::ST_DISPATCH;
                end
            end
            pvk_pkg::ST_DISPATCH: begin
                unique case (r_req.req_type)
                    pvk_pkg::REQ_LOAD:    n_state = pvk_pkg::ST_NEXT;
                    pvk_pkg::REQ_UPDATE:  n_state = (w_s == '0) ? pvk_pkg::ST_NEXT
                                                                : pvk_pkg::ST_GAIN_DIV;
                    default:              n_state = pvk_pkg::ST_ADV_MUL;
                endcase
            end
            pvk_pkg::ST_ADV_MUL:  if (r_cnt == pvk_pkg::MUL_LAST) n_state = pvk_pkg::ST_ADV_DONE;
            pvk_pkg::ST_ADV_DONE: n_state = pvk_pkg::ST_NEXT;
            pvk_pkg::ST_GAIN_DIV: if (r_cnt == pvk_pkg::DIV_LAST) n_state = pvk_pkg::ST_GAIN_DONE;
            pvk_pkg::ST_GAIN_DONE: n_state = pvk_pkg::ST_CORR_MUL;
            pvk_pkg::ST_CORR_MUL: if (r_cnt == pvk_pkg::MUL_LAST) n_state = pvk_pkg::ST_CORR_DONE;
            pvk_pkg::ST_CORR_DONE: n_state = pvk_pkg::ST_VAR_MUL;
            pvk_pkg::ST_VAR_MUL:  if (r_cnt == pvk_pkg::MUL_LAST) n_state = pvk_pkg::ST_VAR_DONE;
            pvk_pkg::ST_VAR_DONE: begin
                n_state = (r_dt == '0) ? pvk_pkg::ST_NEXT : pvk_pkg::ST_VEL_DIV;
            end
            pvk_pkg::ST_VEL_DIV:  if (r_cnt == pvk_pkg::DIV_LAST) n_state = pvk_pkg::ST_VEL_DONE;
            pvk_pkg::ST_VEL_DONE: n_state = pvk_pkg::ST_NEXT;
            pvk_pkg::ST_NEXT: begin
                n_state = (r_axis == 2'd2) ? pvk_pkg::ST_OUT : pvk_pkg::ST_DISPATCH;
            end
            pvk_pkg::ST_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = pvk_pkg::ST_IDLE;
                end
            end
            default: n_state = pvk_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_in_ready = (r_state == pvk_pkg::ST_IDLE);
        w_out_load = (r_state == pvk_pkg::ST_OUT) && (!r_out_valid || o_res.ready);
        w_mul_step = (r_state == pvk_pkg::ST_ADV_MUL) || (r_state == pvk_pkg::ST_CORR_MUL)
                  || (r_state == pvk_pkg::ST_VAR_MUL);
        w_div_step = (r_state == pvk_pkg::ST_GAIN_DIV) || (r_state == pvk_pkg::ST_VEL_DIV);
    end

    assign i_req.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // ------------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvk_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_q         <= '0;
            r_r         <= W'(65536);
            r_dt        <= W'(65536);
            for (int a = 0; a < pvk_pkg::AXES; a++) begin
                r_pos[a] <= '0;
                r_vel[a] <= '0;
                r_var[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pvk_pkg::CFG_Q:  r_q  <= i_cfg_data;
                    pvk_pkg::CFG_R:  r_r  <= i_cfg_data;
                    pvk_pkg::CFG_DT: r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            // state writes of the axis at work
            unique case (r_state)
                pvk_pkg::ST_DISPATCH: begin
                    if (r_req.req_type == pvk_pkg::REQ_LOAD) begin
                        r_pos[r_axis] <= w_pin;
                        r_vel[r_axis] <= w_vin;
                        r_var[r_axis] <= r_q;
                    end else if (r_req.req_type == pvk_pkg::REQ_PREDICT) begin
                        r_var[r_axis] <= ({1'b0, w_var} + {1'b0, r_q} > {1'b0, {W{1'b1}}})
                                       ? {W{1'b1}} : w_var + r_q;
                    end else if (r_req.req_type == pvk_pkg::REQ_UPDATE && w_s == '0) begin
                        r_vel[r_axis] <= '0;
                    end
                end
                pvk_pkg::ST_ADV_DONE: begin
                    if (r_req.req_type == pvk_pkg::REQ_PREDICT) begin
                        r_pos[r_axis] <= w_nx;
                    end
                end
                pvk_pkg::ST_CORR_DONE: r_pos[r_axis] <= w_nx;
                pvk_pkg::ST_VAR_DONE: begin
                    r_var[r_axis] <= w_var_new;
                    if (r_dt == '0) begin
                        r_vel[r_axis] <= '0;
                    end
                end
                pvk_pkg::ST_VEL_DONE: r_vel[r_axis] <= pvk_pkg::sat_s(w_vel_q);
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_req  <= i_req.data;
            r_axis <= 2'd0;
        end
        if (w_mul_step) begin
            r_mul_p <= w_mul_next;
        end
        if (w_div_step) begin
            r_div_rem <= w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
            r_div_q   <= {r_div_q[NW-2:0], w_ge};
        end
        r_cnt <= r_cnt + 1'b1;
        unique case (r_state)
            pvk_pkg::ST_DISPATCH: begin
                r_cnt <= '0;
                if (r_req.req_type == pvk_pkg::REQ_UPDATE) begin
                    r_div_rem <= '0;
                    r_div_q   <= NW'({w_var, {F{1'b0}}});
                    r_div_d   <= w_s;
                end else begin
                    // velocity times step or horizon
                    r_mul_a <= AW'(w_vel_mag);
                    r_neg   <= w_vel[W-1];
                    r_mul_p <= PW'((r_req.req_type == pvk_pkg::REQ_PROJECT)
                                   ? r_req.horizon : r_dt);
                end
            end
            pvk_pkg::ST_ADV_DONE: begin
                if (r_req.req_type == pvk_pkg::REQ_PROJECT) begin
                    r_res[r_axis] <= w_nx;
                end
            end
            pvk_pkg::ST_GAIN_DONE: begin
                // gain times innovation
                r_cnt   <= '0;
                r_gain  <= w_gain;
                r_mul_a <= w_diff_mag;
                r_neg   <= w_diff[W];
                r_mul_p <= PW'(w_gain);
            end
            pvk_pkg::ST_CORR_DONE: begin
                // (1 - gain) times variance
                r_cnt   <= '0;
                r_delta <= $signed({w_nx[W-1], w_nx}) - $signed({w_pos[W-1], w_pos});
                r_mul_a <= AW'(w_var);
                r_neg   <= 1'b0;
                r_mul_p <= PW'(pvk_pkg::ONE_Q - r_gain);
            end
            pvk_pkg::ST_VAR_DONE: begin
                // position change scaled by one over the step
                r_cnt     <= '0;
                r_neg     <= r_delta[W];
                r_div_rem <= '0;
                r_div_q   <= {w_delta_mag, {F{1'b0}}};
                r_div_d   <= {1'b0, r_dt};
            end
            pvk_pkg::ST_NEXT: begin
                if (r_req.req_type != pvk_pkg::REQ_PROJECT) begin
                    r_res[r_axis] <= w_pos;
                end
                r_axis <= r_axis + 2'd1;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.est_x  <= r_res[0];
            r_out.est_y  <= r_res[1];
            r_out.est_z  <= r_res[2];
            r_out.est_vx <= r_vel[0];
            r_out.est_vy <= r_vel[1];
            r_out.est_vz <= r_vel[2];
        end
    end

    // ------------------------------------------------------------------------
    // a new result shows up only from the output step of the sequencer
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pvk_pkg::ST_OUT))
        else $error("result valid without finishing the axes");

    // the axis counter stays on a real axis while work is in flight
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvk_pkg::ST_DISPATCH) |-> (r_axis != 2'd3))
        else $error("axis counter out of range");

    // gain quotient never exceeds one since var never exceeds var + r
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvk_pkg::ST_GAIN_DONE) |-> (r_div_q <= NW'(pvk_pkg::ONE_Q)))
        else $error("gain above one");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis position/velocity tracker. A directed
// table covers reset state, field extremes, saturation, every request type,
// zero-gain updates and an ignored register index, then random request
// sequences run under several noise and step settings. Every result transfer
// is checked field by field against a bit-exact tracker model or a hand-typed result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [1:0] CFG_BAD = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // one line of the directed table: a request or a register write
    typedef struct {
        t_row_kind     kind;
        logic [1:0]    idx;
        logic [31:0]   val;
        pvk_pkg::t_req req;
        bit            has_exp;
        pvk_pkg::t_res exp;
    } t_row;

    // request waiting in the sender, with an optional hand-typed result
    typedef struct {
        pvk_pkg::t_req req;
        bit            has_exp;
        pvk_pkg::t_res exp;
    } t_pend;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    pvk_req_if req_if ();
    pvk_res_if res_if ();

    position_velocity_kalman_tracker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // tracker model state and its copy of the registers
    longint          trk_pos [pvk_pkg::AXES];
    longint          trk_vel [pvk_pkg::AXES];
    longint unsigned trk_var [pvk_pkg::AXES];
    longint unsigned reg_q;
    longint unsigned reg_r;
    longint unsigned reg_dt;

    t_pend         pending_q [$];
    pvk_pkg::t_res est_q [$];
    t_pend         cur_item;
    int            fail_cnt;
    int            idle_cnt;
    int            burst_left;
    int            gap_left;
    int            stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // tracker model
    // ------------------------------------------------------------------------
    function automatic longint clamp_s(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // position moved on by velocity times a Q16.16 duration, floor rounding
    function automatic longint coast(longint p, longint v, longint unsigned t);
        longint prod;
        prod = v * longint'(t);
        return clamp_s(p + (prod >>> pvk_pkg::FRAC_W));
    endfunction

    function automatic pvk_pkg::t_res track_step(pvk_pkg::t_req r);
        longint          pin [pvk_pkg::AXES];
        longint          res [pvk_pkg::AXES];
        longint          x;
        longint          nx;
        longint unsigned ev;
        longint unsigned s;
        longint unsigned gain;
        longint unsigned nv;
        pvk_pkg::t_res   o;
        pin[0] = longint'(r.in_x);
        pin[1] = longint'(r.in_y);
        pin[2] = longint'(r.in_z);
        for (int a = 0; a < pvk_pkg::AXES; a++) begin
            case (pvk_pkg::t_req_type'(r.req_type))
                pvk_pkg::REQ_LOAD: begin
                    trk_pos[a] = pin[a];
                    trk_var[a] = reg_q;
                    case (a)
                        0: trk_vel[a] = longint'(r.in_vx);
                        1: trk_vel[a] = longint'(r.in_vy);
                        default: trk_vel[a] = longint'(r.in_vz);
                    endcase
                end
                pvk_pkg::REQ_PREDICT: begin
                    trk_pos[a] = coast(trk_pos[a], trk_vel[a], reg_dt);
                    nv = trk_var[a] + reg_q;
                    trk_var[a] = (nv > 64'hFFFFFFFF) ? 64'hFFFFFFFF : nv;
                end
                pvk_pkg::REQ_UPDATE: begin
                    x = trk_pos[a];
                    ev = trk_var[a];
                    s = ev + reg_r;
                    gain = (s != 0) ? ((ev << pvk_pkg::FRAC_W) / s) : 0;
                    if (gain > 65536) gain = 65536;
                    nx = clamp_s(x + ((longint'(gain) * (pin[a] - x)) >>> pvk_pkg::FRAC_W));
                    trk_pos[a] = nx;
                    nv = ((65536 - gain) * ev) >> pvk_pkg::FRAC_W;
                    trk_var[a] = (nv > 64'hFFFFFFFF) ? 64'hFFFFFFFF : nv;
                    if (reg_dt == 0) begin
                        trk_vel[a] = 0;
                    end else begin
                        // signed divide truncates toward zero
                        trk_vel[a] = clamp_s(((nx - x) * 65536) / longint'(reg_dt));
                    end
                end
                default: ;
            endcase
            if (pvk_pkg::t_req_type'(r.req_type) == pvk_pkg::REQ_PROJECT)
                res[a] = coast(trk_pos[a], trk_vel[a], longint'(r.horizon));
            else
                res[a] = trk_pos[a];
        end
        o.est_x  = res[0][31:0];
        o.est_y  = res[1][31:0];
        o.est_z  = res[2][31:0];
        o.est_vx = trk_vel[0][31:0];
        o.est_vy = trk_vel[1][31:0];
        o.est_vz = trk_vel[2][31:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // request sender: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pend nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            burst_left   <= 1;
            gap_left     <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                nxt = pending_q.pop_front();
                cur_item     <= nxt;
                req_if.valid <= 1'b1;
                req_if.data  <= nxt.req;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    // some bursts run back to back with no gap at all
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: stall pattern switches between modes now and then
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_mode   <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= ($urandom_range(0, 99) < 3) ? 1'b0 : ~res_if.ready;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // transfer monitor, result check and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pvk_pkg::t_res got;
        pvk_pkg::t_res want;
        pvk_pkg::t_res mdl;
        bit            moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                mdl = track_step(cur_item.req);
                est_q.push_back(cur_item.has_exp ? cur_item.exp : mdl);
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                got = res_if.data;
                if (est_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected result transfer %h", got);
                end else begin
                    want = est_q.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (got[191 - 32*f -: 32] !== want[191 - 32*f -: 32]) begin
                            fail_cnt++;
                            if (fail_cnt <= 10)
                                $display("field %0d mismatch: expected %h, got %h", f,
                                         want[191 - 32*f -: 32], got[191 - 32*f -: 32]);
                        end
                    end
                end
            end
            idle_cnt = moved ? 0 : idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // wait until nothing is queued, presented or outstanding, then settle
    task automatic wait_drained();
        while (pending_q.size() > 0 || req_if.valid || est_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            pvk_pkg::CFG_Q:  reg_q  = val;
            pvk_pkg::CFG_R:  reg_r  = val;
            pvk_pkg::CFG_DT: reg_dt = val;
            default: ; // index above the register file is dropped
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly modest values, sometimes the extremes, sometimes any bit pattern
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 32'h3FFFFF) - 32'h1FFFFF;
        endcase
    endfunction

    function automatic pvk_pkg::t_req rand_req(logic [1:0] kind);
        pvk_pkg::t_req r;
        r.req_type = kind;
        r.in_x  = rand_word();
        r.in_y  = rand_word();
        r.in_z  = rand_word();
        r.in_vx = rand_word();
        r.in_vy = rand_word();
        r.in_vz = rand_word();
        r.horizon = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40000);
        return r;
    endfunction

    function automatic void send(pvk_pkg::t_req r, bit has_exp, pvk_pkg::t_res exp);
        t_pend p;
        p.req = r;
        p.has_exp = has_exp;
        p.exp = exp;
        pending_q.push_back(p);
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_row          dir_tab [];
        pvk_pkg::t_res no_exp;
        pvk_pkg::t_req r;
        logic [1:0]    kind;
        int            pick;
        logic [31:0]   ph_q, ph_r, ph_dt;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= pvk_pkg::CFG_Q;
        i_cfg_data <= '0;
        reg_q      = 0;
        reg_r      = 65536;
        reg_dt     = 65536;
        fail_cnt   = 0;
        idle_cnt   = 0;
        no_exp     = '0;
        for (int a = 0; a < pvk_pkg::AXES; a++) begin
            trk_pos[a] = 0;
            trk_vel[a] = 0;
            trk_var[a] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab = '{
            // after reset everything projects to zero
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0,
              '{pvk_pkg::REQ_PROJECT, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF},
              1, '{0, 0, 0, 0, 0, 0}},
            // load at the field extremes comes straight back
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_LOAD, 32'h7FFFFFFF, 32'h80000000, 0,
              32'h7FFFFFFF, 32'h80000000, 1, 0}, 1,
              '{32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 1}},
            // one step at unit dt saturates both ends
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_PREDICT, 0, 0, 0, 0, 0, 0, 0}, 1,
              '{32'h7FFFFFFF, 32'h80000000, 1, 32'h7FFFFFFF, 32'h80000000, 1}},
            // zero horizon projects the position unchanged
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_PROJECT, 0, 0, 0, 0, 0, 0, 0}, 1,
              '{32'h7FFFFFFF, 32'h80000000, 1, 32'h7FFFFFFF, 32'h80000000, 1}},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0,
              '{pvk_pkg::REQ_PROJECT, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_UPDATE, 32'h80000000, 32'h7FFFFFFF,
              32'hFFFF0000, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_REG, pvk_pkg::CFG_Q, 32'h00008000, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_LOAD, 32'h00010000, 32'hFFFF0000,
              32'h00123456, 32'h00020000, 32'hFFFE8000, 32'h80000000, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_PREDICT, 0, 0, 0, 0, 0, 0, 0},
              0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_UPDATE, 32'h00030000, 32'hFFF00000,
              32'h7FFFFFFF, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_UPDATE, 32'h00030000, 32'hFFF00000,
              32'h80000000, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0,
              '{pvk_pkg::REQ_PROJECT, 0, 0, 0, 0, 0, 0, 32'h00028000}, 0, no_exp},
            // zero gain denominator: position holds, velocity clears
            '{ROW_REG, pvk_pkg::CFG_Q, 32'h0, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_REG, pvk_pkg::CFG_R, 32'h0, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_LOAD, 32'h00050000, 32'hFFFB0000,
              32'h7FFFFFFF, 32'h00010000, 32'h00010000, 32'h00010000, 0}, 1,
              '{32'h00050000, 32'hFFFB0000, 32'h7FFFFFFF, 32'h00010000, 32'h00010000,
                32'h00010000}},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_UPDATE, 32'h00900000, 32'h80000000,
              32'h0, 0, 0, 0, 0}, 1, '{32'h00050000, 32'hFFFB0000, 32'h7FFFFFFF, 0, 0, 0}},
            // write past the register file must leave the step alone
            '{ROW_REG, CFG_BAD, 32'h00000001, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_REG, pvk_pkg::CFG_DT, 32'h00000001, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_REG, pvk_pkg::CFG_R, 32'hFFFFFFFF, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_LOAD, 32'h00010000, 32'h0,
              32'hFFFF0000, 32'h7FFFFFFF, 32'h80000000, 0, 0}, 0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_PREDICT, 0, 0, 0, 0, 0, 0, 0},
              0, no_exp},
            '{ROW_ITEM, pvk_pkg::CFG_Q, 0, '{pvk_pkg::REQ_UPDATE, 32'h7FFFFFFF, 32'h80000000,
              32'h0, 0, 0, 0, 0}, 0, no_exp}
        };

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);
            end
        end

        // random phases: defaults, all-ones extremes, zero noise with tiny step,
        // then two random settings; every phase rewrites all three registers
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: begin ph_q = 0;            ph_r = 32'h00010000; ph_dt = 32'h00010000; end
                1: begin ph_q = 32'hFFFFFFFF; ph_r = 32'hFFFFFFFF; ph_dt = 32'hFFFFFFFF; end
                2: begin ph_q = 0;            ph_r = 0;            ph_dt = 1;            end
                default: begin
                    ph_q  = $urandom_range(0, 32'h00040000);
                    ph_r  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h80000);
                    ph_dt = $urandom_range(1, 32'h00040000);
                end
            endcase
            write_reg(pvk_pkg::CFG_Q, ph_q);
            write_reg(pvk_pkg::CFG_R, ph_r);
            write_reg(pvk_pkg::CFG_DT, ph_dt);
            send(rand_req(pvk_pkg::REQ_LOAD), 0, no_exp);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      kind = pvk_pkg::REQ_LOAD;
                else if (pick < 40) kind = pvk_pkg::REQ_PREDICT;
                else if (pick < 75) kind = pvk_pkg::REQ_UPDATE;
                else if (pick < 95) kind = pvk_pkg::REQ_PROJECT;
                else                kind = $urandom_range(0, 3);
                r = rand_req(kind);
                // keep the sender fed a little ahead of the block
                while (pending_q.size() > 4) @(posedge i_clk);
                send(r, 0, no_exp);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && est_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pvk_pkg.sv
rtl/pvk_req_if.sv
rtl/pvk_res_if.sv
rtl/position_velocity_kalman_tracker_core.sv
bench/tb_top.sv
